FILE: src/periodic_task_tick_dispatcher_macros.svh
// assertion helpers for the periodic task tick dispatcher
`ifndef PERIODIC_TASK_TICK_DISPATCHER_MACROS_SVH
`define PERIODIC_TASK_TICK_DISPATCHER_MACROS_SVH

// same-cycle implication, checked out of reset
`define PTD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PTD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg
// shared widths, codes and types of the periodic task tick dispatcher
// ----------------------------------------------------------------------------
`default_nettype none

package ptd_pkg;

  localparam int NUM_SLOTS  = 8;
  localparam int COUNT_BITS = 32;
  localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam int OP_W       = 2;
  localparam int IDX_W      = 3;
  localparam int PERIOD_W   = 32;
  localparam int MASK_W     = 8;
  localparam int SLOT_OUT_W = 3;
  localparam int STATUS_W   = 2;

  typedef logic [OP_W-1:0]       op_t;
  typedef logic [STATUS_W-1:0]   status_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [SLOT_W-1:0]     slot_idx_t;

  localparam op_t OP_TICK    = 2'd0;
  localparam op_t OP_CREATE  = 2'd1;
  localparam op_t OP_ENABLE  = 2'd2;
  localparam op_t OP_DISABLE = 2'd3;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_FULL      = 2'd1;
  localparam status_t ST_INIT_FAIL = 2'd2;

  localparam count_t CNT_MAX = {COUNT_BITS{1'b1}};

endpackage

`default_nettype wire

FILE: src/periodic_task_tick_dispatcher.sv
// ----------------------------------------------------------------------------
// periodic_task_tick_dispatcher
// table of periodic task slots driven by tick, create, enable and disable items
// ----------------------------------------------------------------------------
// One item is accepted per clock cycle while in_stall is low, and each item
// gives exactly one result. An accepted item is held in an input register; the
// slot table is updated and the result register loaded when the item advances,
// so a result passes through the input register and then the result register.
// The per-item work is one parallel pass over all slot counters (increment,
// saturate, compare against the period) plus a lowest-free-slot search, all
// between the input register and the result register. A stall on the output
// holds both registers and is passed back to the input as in_stall.
`default_nettype none

`include "periodic_task_tick_dispatcher_macros.svh"

module periodic_task_tick_dispatcher (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [ptd_pkg::OP_W-1:0]          in_operation,
  input  wire logic [ptd_pkg::IDX_W-1:0]         in_slot_index,
  input  wire logic [ptd_pkg::PERIOD_W-1:0]      in_period,
  input  wire logic                              in_init_present,
  input  wire logic                              in_init_ok,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [ptd_pkg::MASK_W-1:0]             out_fire_mask,
  output logic [ptd_pkg::SLOT_OUT_W-1:0]         out_slot,
  output logic [ptd_pkg::STATUS_W-1:0]           out_status
);

  import ptd_pkg::*;

  // input register
  logic             s1_valid_r;
  op_t              op_r;
  logic [IDX_W-1:0] idx_r;
  count_t           period_in_r;
  logic             init_present_r;
  logic             init_ok_r;

  // slot table
  logic [NUM_SLOTS-1:0] in_use_r, in_use_nxt;
  logic [NUM_SLOTS-1:0] enabled_r, enabled_nxt;
  count_t               period_r [NUM_SLOTS];
  count_t               period_nxt [NUM_SLOTS];
  count_t               count_r [NUM_SLOTS];
  count_t               count_nxt [NUM_SLOTS];
  count_t               cnt_inc [NUM_SLOTS];

  // result register
  logic                  out_valid_r;
  logic [MASK_W-1:0]     fire_mask_r, fire_mask_nxt;
  logic [SLOT_OUT_W-1:0] slot_r, slot_nxt;
  status_t               status_r, status_nxt;

  logic                 adv;
  logic                 in_accept;
  logic [NUM_SLOTS-1:0] fire_vec;
  logic                 claim_found;
  slot_idx_t            claim_idx;

  assign adv       = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !adv;
  assign in_accept = in_valid && !in_stall;

  // saturating increment per slot
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      cnt_inc[i] = (count_r[i] == CNT_MAX) ? count_r[i] : count_r[i] + COUNT_BITS'(1);
    end
  end

  // lowest free slot
  always_comb begin
    claim_found = 1'b0;
    claim_idx   = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!claim_found && !in_use_r[i]) begin
        claim_found = 1'b1;
        claim_idx   = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    in_use_nxt    = in_use_r;
    enabled_nxt   = enabled_r;
    period_nxt    = period_r;
    count_nxt     = count_r;
    fire_vec      = '0;
    slot_nxt      = '0;
    status_nxt    = ST_OK;
    case (op_r)
      OP_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (in_use_r[i] && enabled_r[i]) begin
            if (cnt_inc[i] >= period_r[i]) begin
              fire_vec[i]  = 1'b1;
              count_nxt[i] = '0;
            end else begin
              count_nxt[i] = cnt_inc[i];
            end
          end
        end
      end
      OP_CREATE: begin
        if (claim_found) begin
          in_use_nxt[claim_idx]  = 1'b1;
          enabled_nxt[claim_idx] = 1'b1;
          period_nxt[claim_idx]  = period_in_r;
          count_nxt[claim_idx]   = '0;
          slot_nxt               = SLOT_OUT_W'(claim_idx);
          status_nxt             = (init_present_r && !init_ok_r) ? ST_INIT_FAIL : ST_OK;
        end else begin
          status_nxt = ST_FULL;
        end
      end
      OP_ENABLE: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (32'(idx_r) == i) begin
            enabled_nxt[i] = 1'b1;
            count_nxt[i]   = period_r[i];
          end
        end
      end
      default: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (32'(idx_r) == i) begin
            enabled_nxt[i] = 1'b0;
          end
        end
      end
    endcase
    fire_mask_nxt = MASK_W'(fire_vec);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r           <= in_operation;
      idx_r          <= in_slot_index;
      period_in_r    <= COUNT_BITS'(in_period);
      init_present_r <= in_init_present;
      init_ok_r      <= in_init_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r  <= '0;
      enabled_r <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        period_r[i] <= '0;
        count_r[i]  <= '0;
      end
    end else if (adv) begin
      in_use_r  <= in_use_nxt;
      enabled_r <= enabled_nxt;
      period_r  <= period_nxt;
      count_r   <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fire_mask_r <= fire_mask_nxt;
      slot_r      <= slot_nxt;
      status_r    <= status_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_fire_mask = fire_mask_r;
  assign out_slot      = slot_r;
  assign out_status    = status_r;

  `PTD_ASSERT_NOW(a_stall_needs_item, in_stall, s1_valid_r && out_valid_r, "input stalled with no item held")
  `PTD_ASSERT_NOW(a_full_means_all_used, adv && op_r == OP_CREATE && status_nxt == ST_FULL, &in_use_r, "table full reported with a free slot")
  `PTD_ASSERT_NEXT(a_create_claims, adv && op_r == OP_CREATE && claim_found, in_use_r != $past(in_use_r), "create did not claim a slot")

endmodule

`default_nettype wire
